@@ design/aarm_pkg.sv @@
// shared types, constants and helper functions for the axis-angle rotation matrix block
// no dependencies
`default_nettype none

package aarm_pkg;

  localparam int CordicSteps = 16;
  localparam int SqrtSteps   = 32;
  localparam int DivSteps    = 31;

  localparam logic signed [33:0] CordicK = 34'sd652032874;
  localparam logic signed [33:0] Q30One  = 34'sd1073741824;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } axis_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
    axis_t              axis;
  } cord_res_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
    logic               zero;
  } norm_res_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic               zero;
  } mat_t;

  // arctangent of 2^-i in units of 2^-20 turn
  function automatic logic signed [23:0] atan_turn(input logic [3:0] i);
    case (i)
      4'd0:    atan_turn = 24'sd131072;
      4'd1:    atan_turn = 24'sd77376;
      4'd2:    atan_turn = 24'sd40884;
      4'd3:    atan_turn = 24'sd20753;
      4'd4:    atan_turn = 24'sd10417;
      4'd5:    atan_turn = 24'sd5213;
      4'd6:    atan_turn = 24'sd2607;
      4'd7:    atan_turn = 24'sd1304;
      4'd8:    atan_turn = 24'sd652;
      4'd9:    atan_turn = 24'sd326;
      4'd10:   atan_turn = 24'sd163;
      4'd11:   atan_turn = 24'sd81;
      4'd12:   atan_turn = 24'sd41;
      4'd13:   atan_turn = 24'sd20;
      4'd14:   atan_turn = 24'sd10;
      4'd15:   atan_turn = 24'sd5;
      default: atan_turn = '0;
    endcase
  endfunction

  // clamp to [-1.0, +1.0] in q2.30
  function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
    if (v > Q30One) begin
      clamp_one = 32'(Q30One);
    end else if (v < -Q30One) begin
      clamp_one = 32'(-Q30One);
    end else begin
      clamp_one = 32'(v);
    end
  endfunction

  // round half up by 2^30
  function automatic logic signed [65:0] rnd30(input logic signed [65:0] p);
    rnd30 = (p + 66'sd536870912) >>> 30;
  endfunction

  // q2.30 to q1.14, rounded half up and saturated
  function automatic logic signed [15:0] to_q14(input logic signed [34:0] v);
    logic signed [34:0] w;
    w = (v + 35'sd32768) >>> 16;
    if (w > 35'sd16384) begin
      to_q14 = 16'sd16384;
    end else if (w < -35'sd16384) begin
      to_q14 = -16'sd16384;
    end else begin
      to_q14 = 16'(w);
    end
  endfunction

endpackage

`default_nettype wire

@@ design/aarm_in_if.sv @@
// input channel: angle and axis transfer with valid/ready
// no dependencies
`default_nettype none

interface aarm_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] turn_angle;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;

  modport source (output valid, turn_angle, axis_x, axis_y, axis_z, input ready);
  modport sink   (input valid, turn_angle, axis_x, axis_y, axis_z, output ready);
endinterface

`default_nettype wire

@@ design/aarm_out_if.sv @@
// result channel: nine matrix entries and zero-axis flag with valid/ready
// no dependencies
`default_nettype none

interface aarm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r00;
  logic signed [15:0] r01;
  logic signed [15:0] r02;
  logic signed [15:0] r10;
  logic signed [15:0] r11;
  logic signed [15:0] r12;
  logic signed [15:0] r20;
  logic signed [15:0] r21;
  logic signed [15:0] r22;
  logic               zero_axis;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, zero_axis,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, zero_axis,
                  output ready);
endinterface

`default_nettype wire

@@ design/aarm_cordic.sv @@
// pipelined rotation-mode cordic: cosine and sine of the angle, axis carried along
// depends on aarm_pkg
`default_nettype none

module aarm_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [15:0]       turn_angle,
  input  aarm_pkg::axis_t   axis_in,
  output logic              out_valid,
  output aarm_pkg::cord_res_t res
);
  import aarm_pkg::*;

  localparam int Lat = CordicSteps + 2;

  logic [Lat-1:0]     vld_r;
  logic signed [16:0] ang;
  logic signed [16:0] ang_red;
  logic               flip;
  logic signed [23:0] z0;

  logic signed [33:0] x_r [CordicSteps+1];
  logic signed [33:0] y_r [CordicSteps+1];
  logic signed [23:0] z_r [CordicSteps+1];
  logic               flip_r [CordicSteps+1];
  axis_t              ax_r [CordicSteps+1];

  logic signed [33:0] xf;
  logic signed [33:0] yf;
  cord_res_t          res_r;

  // fold into a quarter turn either side of zero
  always_comb begin
    ang     = 17'(signed'(turn_angle));
    ang_red = ang;
    flip    = 1'b0;
    if (ang > 17'sd16384) begin
      ang_red = ang - 17'sd32768;
      flip    = 1'b1;
    end else if (ang < -17'sd16384) begin
      ang_red = ang + 17'sd32768;
      flip    = 1'b1;
    end
    z0 = 24'(ang_red) <<< 4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= CordicK;
      y_r[0]    <= '0;
      z_r[0]    <= z0;
      flip_r[0] <= flip;
      ax_r[0]   <= axis_in;
      for (int i = 0; i < CordicSteps; i++) begin
        if (!z_r[i][23]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_turn(4'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_turn(4'(i));
        end
        flip_r[i+1] <= flip_r[i];
        ax_r[i+1]   <= ax_r[i];
      end
      res_r.c    <= clamp_one(xf);
      res_r.s    <= clamp_one(yf);
      res_r.axis <= ax_r[CordicSteps];
    end
  end

  always_comb begin
    xf = flip_r[CordicSteps] ? -x_r[CordicSteps] : x_r[CordicSteps];
    yf = flip_r[CordicSteps] ? -y_r[CordicSteps] : y_r[CordicSteps];
  end

  assign out_valid = vld_r[Lat-1];
  assign res       = res_r;

endmodule

`default_nettype wire

@@ design/aarm_norm.sv @@
// axis normalisation: squared length, digit-by-digit square root, three restoring dividers
// depends on aarm_pkg
`default_nettype none

module aarm_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  aarm_pkg::cord_res_t cin,
  output logic                out_valid,
  output aarm_pkg::norm_res_t res
);
  import aarm_pkg::*;

  localparam int Lat = SqrtSteps + DivSteps + 3;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic [2:0]         neg;
    logic [2:0][15:0]   mag;
    logic               zero;
  } carry_t;

  logic [Lat-1:0]     vld_r;
  logic signed [31:0] sqx, sqy, sqz;
  logic [31:0]        n2;
  carry_t             cin_c;

  logic [63:0] sv_r  [SqrtSteps+1];
  logic [63:0] sr_r  [SqrtSteps+1];
  carry_t      sq_c_r [SqrtSteps+1];
  logic [63:0] ssum  [SqrtSteps];
  logic [63:0] sv_nxt [SqrtSteps];
  logic [63:0] sr_nxt [SqrtSteps];

  logic [30:0] root;
  logic [61:0] rem0 [3];
  logic [61:0] rem_r [DivSteps+1][3];
  logic [30:0] q_r   [DivSteps+1][3];
  logic [30:0] root_r [DivSteps+1];
  carry_t      dv_c_r [DivSteps+1];
  logic [61:0] dsh   [DivSteps];
  logic [61:0] rem_nxt [DivSteps][3];
  logic [30:0] q_nxt   [DivSteps][3];

  logic [30:0]        qc [3];
  logic signed [31:0] u_nxt [3];
  norm_res_t          res_r;

  always_comb begin
    sqx = 32'(cin.axis.x) * 32'(cin.axis.x);
    sqy = 32'(cin.axis.y) * 32'(cin.axis.y);
    sqz = 32'(cin.axis.z) * 32'(cin.axis.z);
    n2  = unsigned'(sqx) + unsigned'(sqy) + unsigned'(sqz);
    cin_c.c      = cin.c;
    cin_c.s      = cin.s;
    cin_c.neg    = {cin.axis.z[15], cin.axis.y[15], cin.axis.x[15]};
    cin_c.mag[0] = cin.axis.x[15] ? 16'(-cin.axis.x) : 16'(cin.axis.x);
    cin_c.mag[1] = cin.axis.y[15] ? 16'(-cin.axis.y) : 16'(cin.axis.y);
    cin_c.mag[2] = cin.axis.z[15] ? 16'(-cin.axis.z) : 16'(cin.axis.z);
    cin_c.zero   = (n2 == 32'd0);
  end

  // square root, one result bit per stage
  always_comb begin
    for (int k = 0; k < SqrtSteps; k++) begin
      ssum[k] = sr_r[k] + (64'd1 << (62 - 2 * k));
      if (sv_r[k] >= ssum[k]) begin
        sv_nxt[k] = sv_r[k] - ssum[k];
        sr_nxt[k] = (sr_r[k] >> 1) + (64'd1 << (62 - 2 * k));
      end else begin
        sv_nxt[k] = sv_r[k];
        sr_nxt[k] = sr_r[k] >> 1;
      end
    end
  end

  // dividend with half the divisor added for rounding
  always_comb begin
    root = sr_r[SqrtSteps][30:0];
    for (int l = 0; l < 3; l++) begin
      rem0[l] = (62'(sq_c_r[SqrtSteps].mag[l]) << 44) + 62'(root >> 1);
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int j = 0; j < DivSteps; j++) begin
      dsh[j] = 62'(root_r[j]) << (DivSteps - 1 - j);
      for (int l = 0; l < 3; l++) begin
        if (rem_r[j][l] >= dsh[j]) begin
          rem_nxt[j][l] = rem_r[j][l] - dsh[j];
          q_nxt[j][l]   = {q_r[j][l][29:0], 1'b1};
        end else begin
          rem_nxt[j][l] = rem_r[j][l];
          q_nxt[j][l]   = {q_r[j][l][29:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qc[l] = (q_r[DivSteps][l] > 31'd1073741824) ? 31'd1073741824 : q_r[DivSteps][l];
      if (dv_c_r[DivSteps].zero) begin
        u_nxt[l] = '0;
      end else if (dv_c_r[DivSteps].neg[l]) begin
        u_nxt[l] = -32'(qc[l]);
      end else begin
        u_nxt[l] = 32'(qc[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_r[0]   <= 64'(n2) << 28;
      sr_r[0]   <= '0;
      sq_c_r[0] <= cin_c;
      for (int k = 0; k < SqrtSteps; k++) begin
        sv_r[k+1]   <= sv_nxt[k];
        sr_r[k+1]   <= sr_nxt[k];
        sq_c_r[k+1] <= sq_c_r[k];
      end
      root_r[0] <= root;
      dv_c_r[0] <= sq_c_r[SqrtSteps];
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= rem0[l];
        q_r[0][l]   <= '0;
      end
      for (int j = 0; j < DivSteps; j++) begin
        root_r[j+1] <= root_r[j];
        dv_c_r[j+1] <= dv_c_r[j];
        for (int l = 0; l < 3; l++) begin
          rem_r[j+1][l] <= rem_nxt[j][l];
          q_r[j+1][l]   <= q_nxt[j][l];
        end
      end
      res_r.c    <= dv_c_r[DivSteps].c;
      res_r.s    <= dv_c_r[DivSteps].s;
      res_r.ux   <= u_nxt[0];
      res_r.uy   <= u_nxt[1];
      res_r.uz   <= u_nxt[2];
      res_r.zero <= dv_c_r[DivSteps].zero;
    end
  end

  assign out_valid = vld_r[Lat-1];
  assign res       = res_r;

endmodule

`default_nettype wire

@@ design/aarm_matrix.sv @@
// rodrigues matrix assembly: outer products, scaling by 1-c and s, rounding to q1.14
// depends on aarm_pkg
`default_nettype none

module aarm_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  aarm_pkg::norm_res_t nin,
  output logic                out_valid,
  output aarm_pkg::mat_t      res
);
  import aarm_pkg::*;

  logic [2:0] vld_r;

  // order: xx yy zz xy xz yz
  logic signed [31:0] uu_r [6];
  // order: xs ys zs
  logic signed [31:0] us1_r [3];
  logic signed [31:0] us2_r [3];
  logic signed [32:0] t_r;
  logic signed [31:0] c1_r, c2_r;
  logic               z1_r, z2_r;
  logic signed [32:0] a_r [6];
  logic signed [31:0] ua [6];
  logic signed [31:0] ub [6];
  logic signed [31:0] uv [3];
  mat_t               res_r;

  always_comb begin
    ua = '{nin.ux, nin.uy, nin.uz, nin.ux, nin.ux, nin.uy};
    ub = '{nin.ux, nin.uy, nin.uz, nin.uy, nin.uz, nin.uz};
    uv = '{nin.ux, nin.uy, nin.uz};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        uu_r[i] <= 32'(rnd30(66'(ua[i]) * 66'(ub[i])));
      end
      for (int i = 0; i < 3; i++) begin
        us1_r[i] <= 32'(rnd30(66'(uv[i]) * 66'(nin.s)));
      end
      t_r  <= 33'sd1073741824 - 33'(nin.c);
      c1_r <= nin.c;
      z1_r <= nin.zero;

      for (int i = 0; i < 6; i++) begin
        a_r[i] <= 33'(rnd30(66'(uu_r[i]) * 66'(t_r)));
      end
      us2_r <= us1_r;
      c2_r  <= c1_r;
      z2_r  <= z1_r;

      res_r.r00  <= to_q14(35'(a_r[0]) + 35'(c2_r));
      res_r.r01  <= to_q14(35'(a_r[3]) - 35'(us2_r[2]));
      res_r.r02  <= to_q14(35'(a_r[4]) + 35'(us2_r[1]));
      res_r.r10  <= to_q14(35'(a_r[3]) + 35'(us2_r[2]));
      res_r.r11  <= to_q14(35'(a_r[1]) + 35'(c2_r));
      res_r.r12  <= to_q14(35'(a_r[5]) - 35'(us2_r[0]));
      res_r.r20  <= to_q14(35'(a_r[4]) - 35'(us2_r[1]));
      res_r.r21  <= to_q14(35'(a_r[5]) + 35'(us2_r[0]));
      res_r.r22  <= to_q14(35'(a_r[2]) + 35'(c2_r));
      res_r.zero <= z2_r;
    end
  end

  assign out_valid = vld_r[2];
  assign res       = res_r;

endmodule

`default_nettype wire

@@ design/axis_angle_rotation_matrix.sv @@
// Axis-angle to 3x3 rotation matrix (Rodrigues form). Takes a binary angle (65536 = one turn)
// and a signed 16-bit axis at any scale; returns nine Q1.14 entries, row-major, and a flag
// for an all-zero axis, which yields cosine on the diagonal and zeros elsewhere. One transfer
// is accepted every cycle unless the result side stalls; data passes the 18-stage cordic,
// the 66-stage normaliser (32 square-root stages and 31 divider stages) and 3 matrix stages.
// A stall on the result side freezes the whole pipeline and input ready drops with it.
// depends on aarm_pkg, aarm_in_if, aarm_out_if, aarm_cordic, aarm_norm, aarm_matrix
`default_nettype none

module axis_angle_rotation_matrix (
  input  logic             clk,
  input  logic             rst_n,
  aarm_in_if.sink          in_ch,
  aarm_out_if.source       out_ch
);
  import aarm_pkg::*;

  logic      adv;
  axis_t     axis_in;
  logic      cord_valid;
  cord_res_t cord_res;
  logic      norm_valid;
  norm_res_t norm_res;
  logic      mat_valid;
  mat_t      mat_res;

  assign adv         = !mat_valid || out_ch.ready;
  assign in_ch.ready = adv;

  assign axis_in.x = in_ch.axis_x;
  assign axis_in.y = in_ch.axis_y;
  assign axis_in.z = in_ch.axis_z;

  aarm_cordic u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_ch.valid),
    .turn_angle (in_ch.turn_angle),
    .axis_in    (axis_in),
    .out_valid  (cord_valid),
    .res        (cord_res)
  );

  aarm_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (cord_valid),
    .cin       (cord_res),
    .out_valid (norm_valid),
    .res       (norm_res)
  );

  aarm_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (norm_valid),
    .nin       (norm_res),
    .out_valid (mat_valid),
    .res       (mat_res)
  );

  assign out_ch.valid     = mat_valid;
  assign out_ch.r00       = mat_res.r00;
  assign out_ch.r01       = mat_res.r01;
  assign out_ch.r02       = mat_res.r02;
  assign out_ch.r10       = mat_res.r10;
  assign out_ch.r11       = mat_res.r11;
  assign out_ch.r12       = mat_res.r12;
  assign out_ch.r20       = mat_res.r20;
  assign out_ch.r21       = mat_res.r21;
  assign out_ch.r22       = mat_res.r22;
  assign out_ch.zero_axis = mat_res.zero;

endmodule

`default_nettype wire
